@@ hdl/slab_free_list_allocator_core_defines.svh @@
// assertion macros shared by the slab allocator modules
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SLAB_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define SLAB_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define SFLA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sfla_pkg.sv @@
// types, constants and helpers for the slab free-list allocator
// no dependencies
`timescale 1ns / 1ps

package sfla_pkg;

  localparam int NUM_SLABS = 256;
  localparam int SLAB_W    = $clog2(NUM_SLABS);
  // head can run past the region after bumps, keep headroom
  localparam int HEAD_W    = SLAB_W + 2;
  localparam int IDX_W     = 8;
  localparam int CNT_W     = 9;
  localparam int SLAB_COUNT_RST = 256;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } sfla_status_e;

  typedef enum logic {
    MODE_ALLOC   = 1'b0,
    MODE_RELEASE = 1'b1
  } sfla_mode_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } sfla_state_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } sfla_cmd_t;

  typedef struct packed {
    logic out_free;
  } sfla_sts_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(NUM_SLABS);
    return (cnt > lim) ? lim : cnt;
  endfunction

endpackage

@@ hdl/sfla_if.sv @@
// request and response channel interfaces of the slab allocator
// depends on sfla_pkg
`timescale 1ns / 1ps

interface sfla_req_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [sfla_pkg::IDX_W-1:0] slab_index;

  modport source (output valid, output mode, output slab_index, input ready);
  modport sink (input valid, input mode, input slab_index, output ready);
endinterface

interface sfla_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [sfla_pkg::IDX_W-1:0] granted_index;
  logic [sfla_pkg::CNT_W-1:0] free_count;

  modport source (output valid, output status, output granted_index, output free_count,
                  input ready);
  modport sink (input valid, input status, input granted_index, input free_count,
                output ready);
endinterface

@@ hdl/sfla_ctrl.sv @@
// control state machine of the slab allocator: capture, then commit
// depends on sfla_pkg and the defines header
`timescale 1ns / 1ps
`include "slab_free_list_allocator_core_defines.svh"

module sfla_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sfla_pkg::sfla_sts_t sts_i,
  output sfla_pkg::sfla_cmd_t cmd_o
);

  sfla_pkg::sfla_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfla_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      sfla_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = sfla_pkg::S_EXEC;
        end
      end
      sfla_pkg::S_EXEC: begin
        // link read data is ready now, wait only for the output slot
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = sfla_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sfla_pkg::S_IDLE;
      end
    endcase
  end

  `SFLA_ASSERT_NEXT(a_capture_to_exec, cmd_o.capture, state_q == sfla_pkg::S_EXEC, "capture did not enter exec")
  `SFLA_ASSERT_NEXT(a_stall_holds, (state_q == sfla_pkg::S_EXEC) && !sts_i.out_free, state_q == sfla_pkg::S_EXEC, "left exec without output slot")
  `SFLA_ASSERT_NOW(a_commit_needs_slot, cmd_o.commit, sts_i.out_free && (state_q == sfla_pkg::S_EXEC), "commit without free output slot")

endmodule

@@ hdl/sfla_dp.sv @@
// datapath of the slab allocator: link memory, head, free count, result register
// depends on sfla_pkg and the defines header
`timescale 1ns / 1ps
`include "slab_free_list_allocator_core_defines.svh"

module sfla_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sfla_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                       mode_i,
  input  logic [sfla_pkg::IDX_W-1:0] slab_index_i,
  input  logic                       rsp_ready_i,
  output logic                       rsp_valid_o,
  output logic [1:0]                 status_o,
  output logic [sfla_pkg::IDX_W-1:0] granted_index_o,
  output logic [sfla_pkg::CNT_W-1:0] free_count_o,
  input  sfla_pkg::sfla_cmd_t        cmd_i,
  output sfla_pkg::sfla_sts_t        sts_o
);

  localparam int HW = sfla_pkg::HEAD_W;
  localparam int SW = sfla_pkg::SLAB_W;
  localparam int CW = sfla_pkg::CNT_W;
  localparam int IW = sfla_pkg::IDX_W;

  // link entries: 0 is null, k+1 points at slab k
  logic [HW-1:0] link_mem [sfla_pkg::NUM_SLABS];

  logic [CW-1:0] slab_count_q;
  logic [HW-1:0] head_q, head_d;
  logic [CW-1:0] free_q, free_d;
  logic          null0_q, null0_d;
  logic          mode_q;
  logic [IW-1:0] idx_q;
  logic [HW-1:0] rd_link_q;

  logic                   out_valid_q;
  sfla_pkg::sfla_status_e out_status_q, status_d;
  logic [IW-1:0]          out_grant_q, grant_d;
  logic [CW-1:0]          out_free_q;

  logic [CW-1:0] eff;
  logic [HW-1:0] head_inc;
  logic          link_null;
  logic          idx_ok;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [HW-1:0] wr_data;

  assign eff      = sfla_pkg::eff_count(slab_count_q);
  assign head_inc = head_q + 1'b1;
  assign idx_ok   = CW'(idx_q) < eff;
  // entry 0 is null after init until slab 0 is released
  assign link_null = (head_q >= HW'(sfla_pkg::NUM_SLABS))
                  || ((head_q == '0) && null0_q)
                  || (rd_link_q == '0);

  always_comb begin
    head_d   = head_q;
    free_d   = free_q;
    null0_d  = null0_q;
    status_d = sfla_pkg::ST_OK;
    grant_d  = '0;
    wr_en    = 1'b0;
    wr_addr  = head_inc[SW-1:0];
    wr_data  = '0;
    if (mode_q == sfla_pkg::MODE_ALLOC) begin
      if (free_q == '0) begin
        status_d = sfla_pkg::ST_EMPTY;
      end else begin
        free_d  = free_q - 1'b1;
        grant_d = head_q[IW-1:0];
        if (link_null) begin
          // bump to the adjacent slab and mark its link null
          head_d = head_inc;
          wr_en  = cmd_i.commit && (head_inc < HW'(sfla_pkg::NUM_SLABS));
        end else begin
          head_d = rd_link_q - 1'b1;
        end
      end
    end else begin
      if (!idx_ok) begin
        status_d = sfla_pkg::ST_RANGE;
      end else begin
        wr_en   = cmd_i.commit;
        wr_addr = idx_q[SW-1:0];
        wr_data = head_inc;
        head_d  = HW'(idx_q);
        if (idx_q == '0) begin
          null0_d = 1'b0;
        end
        if (free_q < eff) begin
          free_d = free_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.capture) begin
      rd_link_q <= link_mem[head_q[SW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      idx_q  <= slab_index_i;
    end
    if (cmd_i.commit) begin
      out_status_q <= status_d;
      out_grant_q  <= grant_d;
      out_free_q   <= free_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slab_count_q <= CW'(sfla_pkg::SLAB_COUNT_RST);
      head_q       <= '0;
      free_q       <= sfla_pkg::eff_count(CW'(sfla_pkg::SLAB_COUNT_RST));
      null0_q      <= 1'b1;
    end else if (cfg_we_i) begin
      slab_count_q <= cfg_wdata_i;
      head_q       <= '0;
      free_q       <= sfla_pkg::eff_count(cfg_wdata_i);
      null0_q      <= 1'b1;
    end else if (cmd_i.commit) begin
      head_q  <= head_d;
      free_q  <= free_d;
      null0_q <= null0_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free  = !out_valid_q || rsp_ready_i;
  assign rsp_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign granted_index_o = out_grant_q;
  assign free_count_o    = out_free_q;

  `SFLA_ASSERT_NOW(a_free_within_count, 1'b1, free_q <= eff, "free count above slab count")
  `SFLA_ASSERT_NEXT(a_alloc_takes_one, cmd_i.commit && !cfg_we_i && (mode_q == sfla_pkg::MODE_ALLOC) && (free_q != '0), free_q == $past(free_q) - 1'b1, "allocate did not take one slab")
  `SFLA_ASSERT_NEXT(a_range_no_change, cmd_i.commit && !cfg_we_i && (mode_q == sfla_pkg::MODE_RELEASE) && !idx_ok, $stable(head_q) && $stable(free_q), "ignored release changed state")

endmodule

@@ hdl/slab_free_list_allocator_core.sv @@
// slab free-list allocator: an item takes two steps, a capture that reads the head link
// from the synchronous link memory, then a commit that updates head, count and result.
// a new item is taken only after the last one commits; the result register frees the
// input side while a result waits. reset is asynchronous, active low: slab
// count 256, head 0, all slabs free, no memory clearing pass.
`timescale 1ns / 1ps

module slab_free_list_allocator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sfla_pkg::CNT_W-1:0] cfg_wdata_i,
  sfla_req_if.sink                   req_i,
  sfla_rsp_if.source                 rsp_o
);

  sfla_pkg::sfla_cmd_t cmd;
  sfla_pkg::sfla_sts_t sts;

  sfla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfla_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .mode_i          (req_i.mode),
    .slab_index_i    (req_i.slab_index),
    .rsp_ready_i     (rsp_o.ready),
    .rsp_valid_o     (rsp_o.valid),
    .status_o        (rsp_o.status),
    .granted_index_o (rsp_o.granted_index),
    .free_count_o    (rsp_o.free_count),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

@@ dv/slab_free_list_allocator_core_checker.sv @@
// checker for the slab free-list allocator: watches the config port and both channels,
// predicts every response and compares it field by field. depends on sfla_pkg and sfla_if
`timescale 1ns / 1ps

module slab_free_list_allocator_core_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sfla_pkg::CNT_W-1:0] cfg_wdata_i,
  sfla_req_if                        req_mon,
  sfla_rsp_if                        rsp_mon,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int IW = sfla_pkg::IDX_W;
  localparam int CW = sfla_pkg::CNT_W;

  typedef struct packed {
    sfla_pkg::sfla_status_e status;
    logic [IW-1:0]          granted;
    logic [CW-1:0]          free_count;
  } slab_grant_t;

  // links held as 0 = null, k+1 = slab k
  int unsigned link_mem [sfla_pkg::NUM_SLABS];
  int unsigned head_slab;
  int unsigned free_slabs;
  int unsigned region;
  int          fails;
  slab_grant_t grant_q [$];

  assign fail_count_o = fails;

  function automatic void restart_region(input logic [CW-1:0] cnt);
    region = (cnt > sfla_pkg::NUM_SLABS) ? sfla_pkg::NUM_SLABS : cnt;
    for (int i = 0; i < sfla_pkg::NUM_SLABS; i++) link_mem[i] = 0;
    head_slab  = 0;
    free_slabs = region;
  endfunction

  function automatic slab_grant_t predict_grant(input logic mode,
                                                input logic [IW-1:0] idx);
    slab_grant_t g;
    int unsigned nxt;
    g.status  = sfla_pkg::ST_OK;
    g.granted = '0;
    nxt       = 0;
    if (mode == sfla_pkg::MODE_ALLOC) begin
      if (free_slabs == 0) begin
        g.status = sfla_pkg::ST_EMPTY;
      end else begin
        free_slabs--;
        g.granted = head_slab[IW-1:0];
        // past the table the link reads as null
        if (head_slab < sfla_pkg::NUM_SLABS) nxt = link_mem[head_slab];
        if (nxt == 0) begin
          // bump to the adjacent slab
          head_slab++;
          if (head_slab < sfla_pkg::NUM_SLABS) link_mem[head_slab] = 0;
        end else begin
          head_slab = nxt - 1;
        end
      end
    end else if (idx >= region) begin
      g.status = sfla_pkg::ST_RANGE;
    end else begin
      link_mem[idx] = head_slab + 1;
      head_slab     = idx;
      if (free_slabs < region) free_slabs++;
    end
    g.free_count = CW'(free_slabs);
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    slab_grant_t want;
    if (!rst_ni) begin
      restart_region(CW'(sfla_pkg::SLAB_COUNT_RST));
      grant_q.delete();
      fails     = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) restart_region(cfg_wdata_i);
      // response first: it always belongs to an older request
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (grant_q.size() == 0) begin
          $error("response transfer with no request waiting");
          fails++;
        end else begin
          want = grant_q.pop_front();
          if (rsp_mon.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_mon.status);
            fails++;
          end
          if (rsp_mon.granted_index !== want.granted) begin
            $error("granted_index: expected %0d, actual %0d", want.granted,
                   rsp_mon.granted_index);
            fails++;
          end
          if (rsp_mon.free_count !== want.free_count) begin
            $error("free_count: expected %0d, actual %0d", want.free_count,
                   rsp_mon.free_count);
            fails++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        grant_q.push_back(predict_grant(req_mon.mode, req_mon.slab_index));
      pending_o <= grant_q.size();
    end
  end

endmodule

@@ dv/slab_free_list_allocator_core_tb.sv @@
// top of the slab allocator testbench: clock, reset, request and config stimulus,
// response back-pressure, watchdog and verdict. depends on sfla_pkg, sfla_if, the checker
`timescale 1ns / 1ps

module slab_free_list_allocator_core_tb;

  localparam int IDLE_LIMIT = 4000;
  localparam int IW         = sfla_pkg::IDX_W;
  localparam int CW         = sfla_pkg::CNT_W;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [CW-1:0] cfg_wdata_i;
  int            fail_count;
  int            pending;
  int            idle_cycles;
  int            rsp_xfers;
  int unsigned   cur_region;
  bit            pressure_done;
  logic          sent_modes [$];
  logic [IW-1:0] held_slabs [$];

  sfla_req_if req_bus ();
  sfla_rsp_if rsp_bus ();

  slab_free_list_allocator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  slab_free_list_allocator_core_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_mon      (req_bus),
    .rsp_mon      (rsp_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // track slabs handed out so that most releases return a slab really in use
  always @(posedge clk_i) begin
    logic m;
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) sent_modes.push_back(req_bus.mode);
      if (rsp_bus.valid && rsp_bus.ready) begin
        rsp_xfers++;
        if (sent_modes.size() > 0) begin
          m = sent_modes.pop_front();
          if (m == sfla_pkg::MODE_ALLOC && rsp_bus.status == sfla_pkg::ST_OK)
            held_slabs.push_back(rsp_bus.granted_index);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || cfg_we_i)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("slab_free_list_allocator_core_tb: FAIL");
        $finish;
      end
    end
  end

  // response side back-pressure, with one long hold-off to fill the block
  initial begin
    int n;
    int g;
    rsp_bus.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!pressure_done && rsp_xfers >= 400) begin
        pressure_done = 1'b1;
        rsp_bus.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      rsp_bus.ready <= 1'b1;
      repeat (n) @(posedge clk_i);
      g = pick_gap();
      if (g > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(input sfla_pkg::sfla_mode_e m, input logic [IW-1:0] idx,
                           input bit steady);
    int g;
    g = steady ? 0 : pick_gap();
    if (g > 0) begin
      req_bus.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.mode       <= m;
    req_bus.slab_index <= idx;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  task automatic drain_responses();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_slab_count(input logic [CW-1:0] cnt);
    drain_responses();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cnt;
    cur_region = (cnt > sfla_pkg::NUM_SLABS) ? sfla_pkg::NUM_SLABS : cnt;
    held_slabs.delete();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_traffic(input int n, input int alloc_pct, input bit steady);
    int            r;
    int            k;
    logic [IW-1:0] idx;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < alloc_pct) begin
        send_item(sfla_pkg::MODE_ALLOC, IW'($urandom), steady);
      end else begin
        r = $urandom_range(0, 99);
        if (held_slabs.size() > 0 && r < 80) begin
          k   = $urandom_range(0, held_slabs.size() - 1);
          idx = held_slabs[k];
          held_slabs.delete(k);
        end else if (r < 92 && cur_region > 0) begin
          // may be a double free or a slab never handed out
          idx = IW'($urandom_range(0, cur_region - 1));
        end else begin
          idx = IW'($urandom_range(0, 255));
        end
        send_item(sfla_pkg::MODE_RELEASE, idx, steady);
      end
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    req_bus.valid      <= 1'b0;
    req_bus.mode       <= sfla_pkg::MODE_ALLOC;
    req_bus.slab_index <= '0;
    idle_cycles        <= 0;
    rsp_xfers     = 0;
    pressure_done = 1'b0;
    cur_region    = sfla_pkg::SLAB_COUNT_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full region after reset: release when full saturates the count
    send_item(sfla_pkg::MODE_RELEASE, 8'd7, 1'b0);
    send_item(sfla_pkg::MODE_ALLOC, 8'hff, 1'b0);
    send_item(sfla_pkg::MODE_ALLOC, 8'h00, 1'b0);
    send_item(sfla_pkg::MODE_ALLOC, 8'h5a, 1'b0);
    send_item(sfla_pkg::MODE_RELEASE, 8'd255, 1'b0);
    send_item(sfla_pkg::MODE_RELEASE, 8'd0, 1'b0);
    // double free of the same slab
    send_item(sfla_pkg::MODE_RELEASE, 8'd0, 1'b0);
    send_item(sfla_pkg::MODE_RELEASE, 8'd0, 1'b0);
    send_item(sfla_pkg::MODE_ALLOC, 8'h00, 1'b0);
    send_item(sfla_pkg::MODE_ALLOC, 8'h00, 1'b0);
    send_item(sfla_pkg::MODE_ALLOC, 8'h00, 1'b0);

    // tiny region: run it empty, then out of range releases
    write_slab_count(9'd3);
    send_item(sfla_pkg::MODE_ALLOC, 8'h00, 1'b0);
    send_item(sfla_pkg::MODE_ALLOC, 8'h00, 1'b0);
    send_item(sfla_pkg::MODE_ALLOC, 8'h00, 1'b0);
    send_item(sfla_pkg::MODE_ALLOC, 8'h00, 1'b0);
    send_item(sfla_pkg::MODE_RELEASE, 8'd3, 1'b0);
    send_item(sfla_pkg::MODE_RELEASE, 8'd255, 1'b0);
    send_item(sfla_pkg::MODE_RELEASE, 8'd2, 1'b0);
    send_item(sfla_pkg::MODE_ALLOC, 8'h00, 1'b0);

    write_slab_count(9'd0);
    send_item(sfla_pkg::MODE_ALLOC, 8'h00, 1'b0);
    send_item(sfla_pkg::MODE_RELEASE, 8'd0, 1'b0);

    // count above the table clamps to the table size
    write_slab_count(9'd511);
    send_item(sfla_pkg::MODE_ALLOC, 8'h00, 1'b0);
    send_item(sfla_pkg::MODE_RELEASE, 8'd255, 1'b0);

    // allocate heavy so the bump pointer walks off the end of the table
    write_slab_count(9'd256);
    run_traffic(300, 90, 1'b0);
    run_traffic(150, 40, 1'b0);
    write_slab_count(9'd0);
    run_traffic(30, 50, 1'b0);
    write_slab_count(9'd1);
    run_traffic(60, 50, 1'b0);
    write_slab_count(9'd2);
    run_traffic(80, 55, 1'b0);
    write_slab_count(9'd257);
    run_traffic(200, 55, 1'b1);
    write_slab_count(CW'($urandom_range(3, 255)));
    run_traffic(200, 60, 1'b0);
    write_slab_count(9'd511);
    run_traffic(200, 50, 1'b0);
    write_slab_count(CW'($urandom_range(3, 40)));
    run_traffic(150, 60, 1'b0);
    write_slab_count(9'd256);
    run_traffic(180, 50, 1'b1);

    drain_responses();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0)
      $display("slab_free_list_allocator_core_tb: PASS");
    else
      $display("slab_free_list_allocator_core_tb: FAIL");
    $finish;
  end

endmodule
